// ===== hw/rtl/proxy_protocol_header_parser_core_macros.svh =====
// Assertion macros for the proxy protocol header parser.
// Define NO_ASSERTIONS to compile the checks away; no other dependencies.
`ifndef PROXY_PROTOCOL_HEADER_PARSER_CORE_MACROS_SVH
`define PROXY_PROTOCOL_HEADER_PARSER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PPHP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pphp assertion failed");
`define PPHP_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("pphp forbidden condition seen");
`else
`define PPHP_ASSERT(name, clk, rst_n, prop)
`define PPHP_ASSERT_NEVER(name, clk, rst_n, prop)
`endif
`endif

// ===== hw/rtl/pphp_pkg.sv =====
// Package for the proxy protocol header parser: payload types, codes and
// header constants. No dependencies.
package pphp_pkg;

  localparam int LINE_LIMIT = 107;
  localparam int CNT_W = ($clog2(LINE_LIMIT) > 6) ? $clog2(LINE_LIMIT) : 6;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_HEALTH      = 4'd1;
  localparam logic [3:0] ST_NOT_PROXY   = 4'd2;
  localparam logic [3:0] ST_UNKNOWN_V1  = 4'd3;
  localparam logic [3:0] ST_BAD_ADDR    = 4'd4;
  localparam logic [3:0] ST_MISSING     = 4'd5;
  localparam logic [3:0] ST_PORT_RANGE  = 4'd6;
  localparam logic [3:0] ST_BAD_SIG     = 4'd7;
  localparam logic [3:0] ST_BAD_VERSION = 4'd8;
  localparam logic [3:0] ST_BAD_CMD     = 4'd9;
  localparam logic [3:0] ST_BAD_LEN     = 4'd10;
  localparam logic [3:0] ST_UNK_FAMILY  = 4'd11;
  localparam logic [3:0] ST_LINE_FAULT  = 4'd12;
  localparam logic [3:0] ST_CLOSED      = 4'd13;

  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_TEXT = 2'd1;
  localparam logic [1:0] VER_BIN  = 2'd2;

  localparam logic [3:0] NO_COMPRESS = 4'd15;

  localparam logic [3:0]  V2_VERSION = 4'h2;
  localparam logic [3:0]  V2_LOCAL   = 4'h0;
  localparam logic [3:0]  V2_PROXY   = 4'h1;
  localparam logic [3:0]  FAM_INET   = 4'd1;
  localparam logic [3:0]  FAM_INET6  = 4'd2;
  localparam logic [15:0] V2_LEN_V4  = 16'd12;
  localparam logic [15:0] V2_LEN_V6  = 16'd36;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  localparam logic [7:0] PROXY_WORD [6] = '{8'h50, 8'h52, 8'h4F, 8'h58, 8'h59, 8'h20};
  localparam logic [7:0] TCP_WORD [3] = '{8'h54, 8'h43, 8'h50};
  localparam logic [7:0] V2_SIG [10] = '{8'h0D, 8'h0A, 8'h00, 8'h0D, 8'h0A,
                                         8'h51, 8'h55, 8'h49, 8'h54, 8'h0A};

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  header_version;
    logic        is_ipv6;
    logic [63:0] source_addr_hi;
    logic [63:0] source_addr_lo;
    logic [15:0] source_port;
  } out_t;

endpackage

// ===== hw/rtl/proxy_protocol_header_parser_core.sv =====
// Proxy protocol (text v1 / binary v2) header parser, one byte per item.
// Depends on pphp_pkg and proxy_protocol_header_parser_core_macros.svh.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries a command and a
// byte: start clears the parser, data feeds one header byte, close reports
// a connection that ended early. Output channel (out_valid_o/out_ready_i/
// out_data_o) carries at most one result per connection: status, header
// version, family and source address and port.
// Every accepted item updates the parser state in the same cycle; a result
// is registered and shows on the output in the cycle after the item that
// decided it. One item is accepted per cycle, sustained, as long as the
// output register is empty or being drained in the same cycle.
// When the receiver stalls with a result pending, in_ready_o drops until
// that result is taken; nothing is lost or repeated.
// After reset the parser idles: data and close items are dropped until a
// start item arrives. Bytes after a result are dropped until the next
// start. IPv6 zero compression is expanded with a single shift on the
// space that ends the source address.
`include "proxy_protocol_header_parser_core_macros.svh"

module proxy_protocol_header_parser_core
  import pphp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LINE, PH_SIG, PH_VERCMD, PH_FAM, PH_LEN, PH_ADDR
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [1:0]          fidx_q, fidx_d;
  logic [0:7][15:0]    grp_q, grp_d;
  logic [15:0]         gacc_q, gacc_d;
  logic [3:0]          cpos_q, cpos_d;
  logic [16:0]         port_q, port_d;
  logic [3:0]          pend_q, pend_d;
  logic [15:0]         v2len_q, v2len_d;
  logic                fam_q, fam_d;
  logic                first_cr_q, first_cr_d;
  logic                bad_q, bad_d;
  logic                v6_seen_q, v6_seen_d;
  logic                v6_lead_q, v6_lead_d;
  logic                v6_trail_q, v6_trail_d;
  logic                v6_tail_q, v6_tail_d;
  logic [2:0]          xdig_q, xdig_d;
  logic [3:0]          ngrp_q, ngrp_d;
  logic [2:0]          v4_oct_q, v4_oct_d;
  logic [2:0]          v4_base_q, v4_base_d;
  logic [3:0]          fam_code_q, fam_code_d;
  logic [1:0]          port_sub_q, port_sub_d;
  logic                v4_saw_q, v4_saw_d;
  logic                port_neg_q, port_neg_d;
  logic [7:0]          v4_cur_q, v4_cur_d;
  logic                out_valid_q;
  out_t                out_q, out_d;

  logic                acc;
  logic                res_valid;
  logic [3:0]          res_status;
  logic [1:0]          res_ver;
  logic                res_addr;

  // Byte and group write ports into the address groups.
  logic                put_en;
  logic [3:0]          put_k;
  logic [7:0]          put_v;
  logic                gw_en;
  logic [2:0]          gw_idx;
  logic [15:0]         gw_val;
  logic                fin_wr;
  logic                grp_clr;

  // Address finalization on the space after the source address.
  logic                fin_ok;
  logic [0:7][15:0]    fin_g;

  // Decimal value of the hex group accumulator, for an embedded IPv4 octet.
  logic                tok_ok;
  logic [13:0]         tok_v;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    logic [13:0] v;
    logic [3:0]  nib;
    v      = '0;
    tok_ok = (xdig_q >= 3'd1) && (xdig_q <= 3'd4);
    for (int i = 3; i >= 0; i--) begin
      nib = gacc_q[4*i +: 4];
      if (i < int'(xdig_q)) begin
        if (nib > 4'd9) tok_ok = 1'b0;
        if ((i == int'(xdig_q) - 1) && (xdig_q > 3'd1) && (nib == 4'd0)) tok_ok = 1'b0;
        v = 14'(v * 14'd10 + {10'd0, nib});
      end
    end
    tok_v = v;
    if (v > 14'd255) tok_ok = 1'b0;
  end

  always_comb begin
    logic [3:0]   n;
    logic [3:0]   gap;
    logic [127:0] fv;
    logic [127:0] keep_hi;
    logic [127:0] keep_lo;
    logic [7:0]   sh_cp;
    logic [7:0]   sh_gap;
    logic [7:0]   sh_end;
    fin_g   = grp_q;
    n       = ngrp_q;
    gap     = '0;
    fv      = '0;
    keep_hi = '0;
    keep_lo = '0;
    sh_cp   = '0;
    sh_gap  = '0;
    sh_end  = '0;
    fin_ok  = 1'b1;
    if (bad_q) begin
      fin_ok = 1'b0;
    end else if (!fam_q) begin
      fin_ok = (v4_oct_q == 3'd4);
    end else begin
      if (!v6_seen_q || v6_lead_q) begin
        fin_ok = 1'b0;
      end else if (v6_tail_q) begin
        if (v4_oct_q != 3'd4) fin_ok = 1'b0;
        else n = 4'(ngrp_q + 4'd2);
      end else if (v6_trail_q) begin
        fin_ok = 1'b0;
      end else if (xdig_q != 3'd0) begin
        if (ngrp_q >= 4'd8) begin
          fin_ok = 1'b0;
        end else begin
          fin_g[ngrp_q[2:0]] = gacc_q;
          n = 4'(ngrp_q + 4'd1);
        end
      end
      if (fin_ok && (cpos_q != NO_COMPRESS)) begin
        if ((n >= 4'd8) || (cpos_q > n)) begin
          fin_ok = 1'b0;
        end else begin
          // Open a run of zero groups at the compression point.
          gap     = 4'(4'd8 - n);
          fv      = fin_g;
          sh_cp   = {cpos_q, 4'd0};
          sh_gap  = {gap, 4'd0};
          sh_end  = 8'(sh_cp + sh_gap);
          keep_hi = ~({128{1'b1}} >> sh_cp);
          keep_lo = {128{1'b1}} >> sh_end;
          fin_g   = (fv & keep_hi) | ((fv >> sh_gap) & keep_lo);
          n       = 4'd8;
        end
      end
      if (n != 4'd8) fin_ok = 1'b0;
    end
  end

  always_comb begin
    logic [7:0]         b;
    logic [CNT_W:0]     pos_inc;
    logic [11:0]        v4_nv;
    logic [19:0]        port_nv;
    logic [3:0]         dval;
    logic               is_dig;
    logic               is_hex;
    logic               go;
    logic [2:0]         oct_new;
    logic [3:0]         ksig;
    logic [15:0]        len_full;
    logic [CNT_W-1:0]   k_next;

    phase_d    = phase_q;
    cnt_d      = cnt_q;
    fidx_d     = fidx_q;
    gacc_d     = gacc_q;
    cpos_d     = cpos_q;
    port_d     = port_q;
    pend_d     = pend_q;
    v2len_d    = v2len_q;
    fam_d      = fam_q;
    first_cr_d = first_cr_q;
    bad_d      = bad_q;
    v6_seen_d  = v6_seen_q;
    v6_lead_d  = v6_lead_q;
    v6_trail_d = v6_trail_q;
    v6_tail_d  = v6_tail_q;
    xdig_d     = xdig_q;
    ngrp_d     = ngrp_q;
    v4_oct_d   = v4_oct_q;
    v4_base_d  = v4_base_q;
    fam_code_d = fam_code_q;
    port_sub_d = port_sub_q;
    v4_saw_d   = v4_saw_q;
    port_neg_d = port_neg_q;
    v4_cur_d   = v4_cur_q;

    res_valid  = 1'b0;
    res_status = ST_OK;
    res_ver    = VER_NONE;
    res_addr   = 1'b0;
    put_en     = 1'b0;
    put_k      = '0;
    put_v      = '0;
    gw_en      = 1'b0;
    gw_idx     = '0;
    gw_val     = '0;
    fin_wr     = 1'b0;
    grp_clr    = 1'b0;

    b        = in_data_i.data_byte;
    pos_inc  = (CNT_W+1)'({1'b0, cnt_q} + 1'b1);
    v4_nv    = 12'(v4_cur_q * 12'd10 + 12'(b - CH_0));
    port_nv  = 20'(port_q * 20'd10 + 20'(b - CH_0));
    is_dig   = (b >= CH_0) && (b <= CH_9);
    is_hex   = 1'b1;
    dval     = '0;
    go       = 1'b1;
    oct_new  = v4_oct_q;
    ksig     = (cnt_q < CNT_W'(10)) ? cnt_q[3:0] : 4'd9;
    len_full = {v2len_q[15:8], b};
    k_next   = CNT_W'(cnt_q + 1'b1);

    if (is_dig) dval = 4'(b - CH_0);
    else if ((b >= CH_LA) && (b <= CH_LF_HEX)) dval = 4'(b - CH_LA + 8'd10);
    else if ((b >= CH_UA) && (b <= CH_UF)) dval = 4'(b - CH_UA + 8'd10);
    else is_hex = 1'b0;

    if (acc) begin
      if (in_data_i.cmd == CMD_START) begin
        phase_d    = PH_LINE;
        cnt_d      = '0;
        fidx_d     = '0;
        grp_clr    = 1'b1;
        gacc_d     = '0;
        cpos_d     = NO_COMPRESS;
        port_d     = '0;
        pend_d     = ST_OK;
        v2len_d    = '0;
        fam_d      = 1'b0;
        first_cr_d = 1'b0;
        bad_d      = 1'b0;
        v6_seen_d  = 1'b0;
        v6_lead_d  = 1'b0;
        v6_trail_d = 1'b0;
        v6_tail_d  = 1'b0;
        xdig_d     = '0;
        ngrp_d     = '0;
        v4_oct_d   = '0;
        v4_base_d  = '0;
        fam_code_d = '0;
        port_sub_d = '0;
        v4_saw_d   = 1'b0;
        port_neg_d = 1'b0;
        v4_cur_d   = '0;
      end else if ((phase_q != PH_IDLE) && (in_data_i.cmd == CMD_CLOSE)) begin
        res_valid  = 1'b1;
        res_status = ST_CLOSED;
        res_ver    = (phase_q == PH_LINE) ? VER_NONE : VER_BIN;
      end else if ((phase_q != PH_IDLE) && (in_data_i.cmd == CMD_DATA)) begin
        case (phase_q)
          PH_LINE: begin
            if (b == CH_NUL) begin
              res_valid  = 1'b1;
              res_status = ST_LINE_FAULT;
            end else if (b == CH_LF) begin
              if ((cnt_q == CNT_W'(1)) && first_cr_q) begin
                phase_d = PH_SIG;
                cnt_d   = '0;
                pend_d  = ST_OK;
                fam_d   = 1'b0;
                grp_clr = 1'b1;
                port_d  = '0;
              end else begin
                res_valid = 1'b1;
                res_ver   = VER_TEXT;
                if (pend_q != ST_OK) begin
                  res_status = pend_q;
                  if (pend_q == ST_NOT_PROXY) res_ver = VER_NONE;
                end else if (fidx_q == 2'd0) begin
                  if (cnt_q < CNT_W'(6)) begin
                    res_status = ST_NOT_PROXY;
                    res_ver    = VER_NONE;
                  end else begin
                    res_status = ST_UNKNOWN_V1;
                  end
                end else if (fidx_q != 2'd3) begin
                  res_status = ST_MISSING;
                end else if (port_neg_q || (port_q == 17'd0) || port_q[16]) begin
                  res_status = ST_PORT_RANGE;
                end else begin
                  res_status = ST_OK;
                  res_addr   = 1'b1;
                end
              end
            end else if (pos_inc >= (CNT_W+1)'(LINE_LIMIT)) begin
              res_valid  = 1'b1;
              res_status = ST_LINE_FAULT;
            end else begin
              if (cnt_q == '0) first_cr_d = (b == CH_CR);
              cnt_d = pos_inc[CNT_W-1:0];
              if (pend_q == ST_OK) begin
                case (fidx_q)
                  2'd0: begin
                    if (cnt_q < CNT_W'(6)) begin
                      if (b != PROXY_WORD[cnt_q[2:0]]) pend_d = ST_NOT_PROXY;
                    end else if (cnt_q < CNT_W'(9)) begin
                      if (b != TCP_WORD[2'(cnt_q - CNT_W'(6))]) pend_d = ST_UNKNOWN_V1;
                    end else if (cnt_q == CNT_W'(9)) begin
                      if (b == CH_4) fam_d = 1'b0;
                      else if (b == CH_6) fam_d = 1'b1;
                      else pend_d = ST_UNKNOWN_V1;
                    end else if (b != CH_SPACE) begin
                      pend_d = ST_UNKNOWN_V1;
                    end else begin
                      fidx_d    = 2'd1;
                      v6_tail_d = !fam_q;
                      v4_base_d = '0;
                    end
                  end
                  2'd1: begin
                    if (b == CH_SPACE) begin
                      if (fin_ok) begin
                        fidx_d = 2'd2;
                        fin_wr = fam_q;
                      end else begin
                        pend_d = ST_BAD_ADDR;
                      end
                    end else if (!bad_q) begin
                      // Once the address is known bad, freeze its state.
                      if (fam_q && !v6_tail_q) begin
                        if (!v6_seen_q) begin
                          v6_seen_d = 1'b1;
                          if (b == CH_COLON) begin
                            v6_lead_d = 1'b1;
                            go        = 1'b0;
                          end
                        end else if (v6_lead_q) begin
                          v6_lead_d = 1'b0;
                          if (b != CH_COLON) begin
                            bad_d = 1'b1;
                            go    = 1'b0;
                          end
                        end
                        if (go) begin
                          v6_trail_d = 1'b0;
                          if (is_hex) begin
                            if (xdig_q >= 3'd4) begin
                              bad_d = 1'b1;
                            end else begin
                              gacc_d = {gacc_q[11:0], dval};
                              xdig_d = 3'(xdig_q + 3'd1);
                            end
                          end else if (b == CH_COLON) begin
                            if (xdig_q == 3'd0) begin
                              if (cpos_q != NO_COMPRESS) bad_d = 1'b1;
                              else cpos_d = ngrp_q;
                            end else begin
                              v6_trail_d = 1'b1;
                              if (ngrp_q >= 4'd8) begin
                                bad_d = 1'b1;
                              end else begin
                                gw_en  = 1'b1;
                                gw_idx = ngrp_q[2:0];
                                gw_val = gacc_q;
                                ngrp_d = 4'(ngrp_q + 4'd1);
                                xdig_d = '0;
                                gacc_d = '0;
                              end
                            end
                          end else if (b == CH_DOT) begin
                            if ((ngrp_q > 4'd6) || !tok_ok) begin
                              bad_d = 1'b1;
                            end else begin
                              v4_base_d = ngrp_q[2:0];
                              v4_oct_d  = 3'd1;
                              v4_saw_d  = 1'b0;
                              v4_cur_d  = '0;
                              put_en    = 1'b1;
                              put_k     = {ngrp_q[2:0], 1'b0};
                              put_v     = tok_v[7:0];
                              v6_tail_d = 1'b1;
                            end
                          end else begin
                            bad_d = 1'b1;
                          end
                        end
                      end else begin
                        // Dotted quad, alone or as the tail of an IPv6 address.
                        if (is_dig) begin
                          if ((v4_saw_q && (v4_cur_q == 8'd0)) || (v4_nv > 12'd255)) begin
                            bad_d = 1'b1;
                          end else begin
                            v4_cur_d = v4_nv[7:0];
                            if (!v4_saw_q) oct_new = 3'(v4_oct_q + 3'd1);
                            v4_oct_d = oct_new;
                            if (oct_new > 3'd4) begin
                              bad_d = 1'b1;
                            end else begin
                              v4_saw_d = 1'b1;
                              put_en   = 1'b1;
                              put_k    = 4'({v4_base_q, 1'b0} + {1'b0, oct_new} - 4'd1);
                              put_v    = v4_nv[7:0];
                            end
                          end
                        end else if ((b == CH_DOT) && v4_saw_q) begin
                          if (v4_oct_q == 3'd4) begin
                            bad_d = 1'b1;
                          end else begin
                            v4_cur_d = '0;
                            v4_saw_d = 1'b0;
                          end
                        end else begin
                          bad_d = 1'b1;
                        end
                      end
                    end
                  end
                  2'd2: begin
                    if (b == CH_SPACE) begin
                      fidx_d     = 2'd3;
                      port_sub_d = '0;
                      port_d     = '0;
                    end
                  end
                  default: begin
                    if ((port_sub_q == 2'd0) &&
                        ((b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR)))) begin
                      // skip leading white space
                    end else if ((port_sub_q == 2'd0) &&
                                 ((b == CH_PLUS) || (b == CH_MINUS))) begin
                      port_neg_d = (b == CH_MINUS);
                      port_sub_d = 2'd1;
                    end else if (port_sub_q != 2'd3) begin
                      if (is_dig) begin
                        port_d     = (port_nv > 20'd65535) ? 17'h10000 : port_nv[16:0];
                        port_sub_d = 2'd2;
                      end else begin
                        port_sub_d = 2'd3;
                      end
                    end
                  end
                endcase
              end
            end
          end
          PH_SIG: begin
            if (b != V2_SIG[ksig]) pend_d = ST_BAD_SIG;
            cnt_d = CNT_W'(ksig + 4'd1);
            if (ksig == 4'd9) begin
              if ((pend_q != ST_OK) || (b != V2_SIG[ksig])) begin
                res_valid  = 1'b1;
                res_status = ST_BAD_SIG;
                res_ver    = VER_BIN;
              end else begin
                phase_d = PH_VERCMD;
              end
            end
          end
          PH_VERCMD: begin
            res_ver = VER_BIN;
            if (b[7:4] != V2_VERSION) begin
              res_valid  = 1'b1;
              res_status = ST_BAD_VERSION;
            end else if (b[3:0] == V2_LOCAL) begin
              res_valid  = 1'b1;
              res_status = ST_HEALTH;
            end else if (b[3:0] != V2_PROXY) begin
              res_valid  = 1'b1;
              res_status = ST_BAD_CMD;
            end else begin
              phase_d = PH_FAM;
            end
          end
          PH_FAM: begin
            fam_code_d = b[7:4];
            fam_d      = (b[7:4] == FAM_INET6);
            phase_d    = PH_LEN;
            cnt_d      = '0;
          end
          PH_LEN: begin
            res_ver = VER_BIN;
            if (cnt_q == '0) begin
              v2len_d = {b, 8'd0};
              cnt_d   = CNT_W'(1);
            end else begin
              v2len_d = len_full;
              if (fam_code_q == FAM_INET) begin
                if (len_full != V2_LEN_V4) begin
                  res_valid  = 1'b1;
                  res_status = ST_BAD_LEN;
                end
              end else if (fam_code_q == FAM_INET6) begin
                if (len_full != V2_LEN_V6) begin
                  res_valid  = 1'b1;
                  res_status = ST_BAD_LEN;
                end
              end else begin
                res_valid  = 1'b1;
                res_status = ST_UNK_FAMILY;
              end
              if (!res_valid) begin
                phase_d = PH_ADDR;
                cnt_d   = '0;
              end
            end
          end
          PH_ADDR: begin
            if (fam_q) begin
              if (cnt_q < CNT_W'(16)) begin
                put_en = 1'b1;
                put_k  = cnt_q[3:0];
                put_v  = b;
              end else if (cnt_q == CNT_W'(32)) begin
                port_d = {1'b0, b, 8'd0};
              end else if (cnt_q == CNT_W'(33)) begin
                port_d = {port_q[16:8], b};
              end
            end else begin
              if (cnt_q < CNT_W'(4)) begin
                put_en = 1'b1;
                put_k  = cnt_q[3:0];
                put_v  = b;
              end else if (cnt_q == CNT_W'(8)) begin
                port_d = {1'b0, b, 8'd0};
              end else if (cnt_q == CNT_W'(9)) begin
                port_d = {port_q[16:8], b};
              end
            end
            cnt_d = k_next;
            if (16'(k_next) >= v2len_q) begin
              res_valid  = 1'b1;
              res_status = ST_OK;
              res_ver    = VER_BIN;
              res_addr   = 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      if (res_valid) phase_d = PH_IDLE;
    end
  end

  // Apply the address group writes; at most one source is active per item.
  always_comb begin
    grp_d = grp_q;
    if (grp_clr) begin
      grp_d = '0;
    end else if (fin_wr) begin
      grp_d = fin_g;
    end else if (gw_en) begin
      grp_d[gw_idx] = gw_val;
    end else if (put_en) begin
      if (put_k[0]) grp_d[put_k[3:1]][7:0] = put_v;
      else grp_d[put_k[3:1]][15:8] = put_v;
    end
  end

  always_comb begin
    logic [127:0] gv;
    gv    = grp_q;
    out_d = '0;
    out_d.status         = res_status;
    out_d.header_version = res_ver;
    if (res_addr) begin
      out_d.is_ipv6     = fam_q;
      out_d.source_port = port_q[15:0];
      if (fam_q) begin
        out_d.source_addr_hi = gv[127:64];
        out_d.source_addr_lo = gv[63:0];
      end else begin
        out_d.source_addr_lo = {32'd0, gv[127:96]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      fidx_q      <= '0;
      grp_q       <= '0;
      gacc_q      <= '0;
      cpos_q      <= NO_COMPRESS;
      port_q      <= '0;
      pend_q      <= ST_OK;
      v2len_q     <= '0;
      fam_q       <= 1'b0;
      first_cr_q  <= 1'b0;
      bad_q       <= 1'b0;
      v6_seen_q   <= 1'b0;
      v6_lead_q   <= 1'b0;
      v6_trail_q  <= 1'b0;
      v6_tail_q   <= 1'b0;
      xdig_q      <= '0;
      ngrp_q      <= '0;
      v4_oct_q    <= '0;
      v4_base_q   <= '0;
      fam_code_q  <= '0;
      port_sub_q  <= '0;
      v4_saw_q    <= 1'b0;
      port_neg_q  <= 1'b0;
      v4_cur_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      fidx_q      <= fidx_d;
      grp_q       <= grp_d;
      gacc_q      <= gacc_d;
      cpos_q      <= cpos_d;
      port_q      <= port_d;
      pend_q      <= pend_d;
      v2len_q     <= v2len_d;
      fam_q       <= fam_d;
      first_cr_q  <= first_cr_d;
      bad_q       <= bad_d;
      v6_seen_q   <= v6_seen_d;
      v6_lead_q   <= v6_lead_d;
      v6_trail_q  <= v6_trail_d;
      v6_tail_q   <= v6_tail_d;
      xdig_q      <= xdig_d;
      ngrp_q      <= ngrp_d;
      v4_oct_q    <= v4_oct_d;
      v4_base_q   <= v4_base_d;
      fam_code_q  <= fam_code_d;
      port_sub_q  <= port_sub_d;
      v4_saw_q    <= v4_saw_d;
      port_neg_q  <= port_neg_d;
      v4_cur_q    <= v4_cur_d;
      if (acc && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload holds while a result waits.
  always_ff @(posedge clk_i) begin
    if (acc && res_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PPHP_ASSERT(a_result_from_item, clk_i, rst_ni, $rose(out_valid_q) |-> $past(acc))
  `PPHP_ASSERT(a_idle_after_result, clk_i, rst_ni, $rose(out_valid_q) |-> phase_q == PH_IDLE)
  `PPHP_ASSERT(a_fail_no_addr, clk_i, rst_ni, (out_valid_q && out_q.status != ST_OK) |-> (out_q.is_ipv6 == 1'b0 && out_q.source_addr_hi == '0 && out_q.source_addr_lo == '0 && out_q.source_port == '0))
  `PPHP_ASSERT_NEVER(a_ok_has_version, clk_i, rst_ni, out_valid_q && out_q.status == ST_OK && out_q.header_version == VER_NONE)

endmodule
